FILE: rtl/mrca_pkg.sv
// Package for the MIDI retune channel allocator.
// Request, result, table entry and cell command types, plus status constants.
// No dependencies.
`timescale 1ns / 1ps

package mrca_pkg;

  localparam int NUM_KEYS  = 128;
  localparam int KEY_W     = 7;
  localparam int CH_W      = 4;

  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_BEND      = 8'he0;
  localparam logic [7:0] ST_KIND_MASK = 8'hf0;
  localparam logic [7:0] FREE_MARK    = 8'hff;

  typedef struct packed {
    logic        action;
    logic [7:0]  status_in;
    logic [6:0]  data1_in;
    logic [6:0]  data2_in;
    logic [1:0]  length_in;
    logic [12:0] time_in;
    logic [6:0]  entry_key;
    logic [7:0]  entry_note;
    logic [13:0] entry_bend;
  } in_t;

  typedef struct packed {
    logic [7:0]  status_out;
    logic [6:0]  data1_out;
    logic [6:0]  data2_out;
    logic [1:0]  length_out;
    logic [12:0] time_out;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0]  note;
    logic [13:0] bend;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{note: FREE_MARK, bend: 14'd0};

  typedef struct packed {
    logic       active;
    logic       find_free;
    logic [7:0] note;
  } cell_cmd_t;

endpackage

FILE: rtl/mrca_cell.sv
// One channel cell: holds the note sounding on its channel.
// Takes the search token from its lower neighbor and passes it on.
// Depends on mrca_pkg.
`timescale 1ns / 1ps

module mrca_cell (
  input  logic               clk,
  input  logic               rst,
  input  mrca_pkg::cell_cmd_t cmd,
  input  logic               chain_in,
  output logic               chain_out,
  output logic               take
);
  import mrca_pkg::*;

  logic [7:0] note;
  logic       match;

  assign match     = cmd.find_free ? (note == FREE_MARK) : (note == cmd.note);
  assign take      = cmd.active && match && !chain_in;
  assign chain_out = chain_in || (cmd.active && match);

  always_ff @(posedge clk) begin
    if (rst) begin
      note <= FREE_MARK;
    end else if (take) begin
      note <= cmd.find_free ? cmd.note : FREE_MARK;
    end
  end

endmodule

FILE: rtl/mrca_key_table.sv
// Key table: 128 entries of mapped note and bend, registered read.
// Per-key valid bits make unwritten keys read as unmapped after reset.
// Depends on mrca_pkg.
`timescale 1ns / 1ps

module mrca_key_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [mrca_pkg::KEY_W-1:0]    waddr,
  input  mrca_pkg::entry_t              wdata,
  input  logic                          re,
  input  logic [mrca_pkg::KEY_W-1:0]    raddr,
  output mrca_pkg::entry_t              rdata
);
  import mrca_pkg::*;

  entry_t              mem [NUM_KEYS];
  entry_t              rd_q;
  logic [NUM_KEYS-1:0] valid;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : ENTRY_RESET;

endmodule

FILE: rtl/midi_retune_channel_allocator_core.sv
// MIDI retune channel allocator, top level.
// Usage: drive request and raise start; a request is taken at a rising edge
// with start high and busy low. action=1 loads one key table entry, action=0
// is a MIDI event. Results appear on result for one cycle with strobe high;
// the receiver cannot stall, so every strobe must be captured.
// Latency: an event accepted at edge N yields its first result in the cycle
// after edge N (key table read, then channel search through the cell row).
// A note-on that finds a channel yields a pitch bend (last=0) and, in the
// next cycle, the note-on (last=1); busy stays high while both are shown.
// Throughput: one request per cycle for loads, pass-through, note-off and
// dropped events; a note-on that allocates holds busy through its bend and
// note-on results, and the next request is then taken from idle. The rate is
// set by the single result port and the registered table read.
// The channel search ripples a token combinationally through NUM_CHANNELS cells.
// Reset: synchronous; all channels free and all keys unmapped at once
// (valid bits, no clearing pass).
// Depends on mrca_pkg, mrca_key_table, mrca_cell.
`timescale 1ns / 1ps

module midi_retune_channel_allocator_core #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mrca_pkg::in_t  request,
  output logic           strobe,
  output mrca_pkg::out_t result
);
  import mrca_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;

  logic [1:0]  state;
  logic [1:0]  state_next;
  in_t         req_q;
  logic [CH_W-1:0] ch_q;

  logic        accept;
  logic        is_event;
  logic        is_load;
  entry_t      ent;
  entry_t      wr_entry;

  logic [7:0]  kind;
  logic        is_on;
  logic        is_note;
  logic        mapped;
  logic        found;
  logic        need_second;
  logic [CH_W-1:0] ch;

  cell_cmd_t   cmd;
  logic [NUM_CHANNELS:0]   chain;
  logic [NUM_CHANNELS-1:0] take;

  assign accept   = start && !busy;
  assign is_event = accept && !request.action;
  assign is_load  = accept && request.action;
  assign wr_entry = '{note: request.entry_note, bend: request.entry_bend};

  mrca_key_table u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (is_load),
    .waddr (request.entry_key),
    .wdata (wr_entry),
    .re    (is_event),
    .raddr (request.data1_in),
    .rdata (ent)
  );

  assign kind    = req_q.status_in & ST_KIND_MASK;
  assign is_on   = (kind == ST_NOTE_ON);
  assign is_note = is_on || (kind == ST_NOTE_OFF);
  assign mapped  = !ent.note[7];

  assign cmd.active    = (state == S_LOOK) && is_note && mapped;
  assign cmd.find_free = is_on;
  assign cmd.note      = ent.note;

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    mrca_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .take      (take[i])
    );
  end

  assign found = chain[NUM_CHANNELS];

  always_comb begin
    ch = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (take[i]) begin
        ch = ch | CH_W'(i);
      end
    end
  end

  assign need_second = cmd.active && is_on && found;

  always_comb begin
    busy = 1'b0;
    unique case (state)
      S_LOOK:   busy = need_second;
      S_SECOND: busy = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_comb begin
    state_next = S_IDLE;
    unique case (state)
      S_SECOND: state_next = S_IDLE;
      S_LOOK: begin
        if (need_second) begin
          state_next = S_SECOND;
        end else if (is_event) begin
          state_next = S_LOOK;
        end
      end
      default: begin
        if (is_event) begin
          state_next = S_LOOK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (is_event) begin
      req_q <= request;
    end
    if (need_second) begin
      ch_q <= ch;
    end
  end

  always_comb begin
    strobe            = 1'b0;
    result.status_out = req_q.status_in;
    result.data1_out  = req_q.data1_in;
    result.data2_out  = req_q.data2_in;
    result.length_out = req_q.length_in;
    result.time_out   = req_q.time_in;
    result.last       = 1'b1;
    unique case (state)
      S_LOOK: begin
        if (!is_note) begin
          strobe = 1'b1;
        end else if (cmd.active && found) begin
          strobe = 1'b1;
          if (is_on) begin
            result.status_out = ST_BEND | {4'h0, ch};
            result.data1_out  = ent.bend[6:0];
            result.data2_out  = ent.bend[13:7];
            result.last       = 1'b0;
          end else begin
            result.status_out = ST_NOTE_OFF | {4'h0, ch};
            result.data1_out  = ent.note[6:0];
          end
        end
      end
      S_SECOND: begin
        strobe            = 1'b1;
        result.status_out = ST_NOTE_ON | {4'h0, ch_q};
        result.data1_out  = ent.note[6:0];
      end
      default: strobe = 1'b0;
    endcase
  end

  a_second_after_look: assert property (@(posedge clk) disable iff (rst)
    state == S_SECOND |-> $past(state) == S_LOOK)
    else $error("second result without a lookup");

  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    $onehot0(take))
    else $error("more than one channel taken");

  a_bend_then_note: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.last)
    else $error("bend not followed by note-on");

  a_no_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !strobe)
    else $error("result while idle");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for midi_retune_channel_allocator_core.
// Directed table then random traffic, checked against a behavioral predictor.
// Depends on mrca_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;
  import mrca_pkg::*;

  localparam int NCHAN = 16;
  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;
  localparam out_t NO_MSG    = '0;

  typedef struct {
    in_t  req;
    bit   typed;
    int   count;
    out_t msg0;
    out_t msg1;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  request = '0;
  logic busy;
  logic strobe;
  out_t result;

  logic [7:0]  key_note [NUM_KEYS];
  logic [13:0] key_bend [NUM_KEYS];
  logic [7:0]  chan_note [NCHAN];
  out_t        retuned_msgs [$];
  int          mismatches = 0;

  midi_retune_channel_allocator_core DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic out_t msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                               logic [1:0] len, logic [12:0] tm, logic lst);
    out_t m;
    m.status_out = st;
    m.data1_out  = d1;
    m.data2_out  = d2;
    m.length_out = len;
    m.time_out   = tm;
    m.last       = lst;
    return m;
  endfunction

  function automatic in_t ev(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                             logic [1:0] len, logic [12:0] tm);
    in_t r;
    r = '0;
    r.action    = ACT_EVENT;
    r.status_in = st;
    r.data1_in  = d1;
    r.data2_in  = d2;
    r.length_in = len;
    r.time_in   = tm;
    return r;
  endfunction

  function automatic in_t ld(logic [6:0] key, logic [7:0] note, logic [13:0] bend);
    in_t r;
    r = '0;
    r.action     = ACT_LOAD;
    r.length_in  = 2'd1;
    r.entry_key  = key;
    r.entry_note = note;
    r.entry_bend = bend;
    return r;
  endfunction

  function automatic void retune_reset();
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_note[k] = FREE_MARK;
      key_bend[k] = '0;
    end
    for (int c = 0; c < NCHAN; c++) chan_note[c] = FREE_MARK;
  endfunction

  // Applies one request to the predicted state; returns the number of results.
  function automatic int retune_event(in_t it, bit queue_it);
    logic [7:0]  kind;
    logic [7:0]  note;
    logic [13:0] bend;
    logic [3:0]  chan;
    bit          found;
    out_t        r [2];
    int          n;
    n = 0;
    found = 1'b0;
    chan = '0;
    kind = it.status_in & ST_KIND_MASK;
    if (it.action == ACT_LOAD) begin
      key_note[it.entry_key] = it.entry_note;
      key_bend[it.entry_key] = it.entry_bend;
    end else if (kind == ST_NOTE_ON || kind == ST_NOTE_OFF) begin
      note = key_note[it.data1_in];
      bend = key_bend[it.data1_in];
      if (!note[7]) begin
        for (int c = 0; c < NCHAN; c++) begin
          if (!found && ((kind == ST_NOTE_ON) ? (chan_note[c] == FREE_MARK)
                                              : (chan_note[c] == note))) begin
            found = 1'b1;
            chan = 4'(c);
          end
        end
        if (found && kind == ST_NOTE_ON) begin
          chan_note[chan] = note;
          r[0] = msg(ST_BEND | {4'd0, chan}, bend[6:0], bend[13:7],
                     it.length_in, it.time_in, 1'b0);
          r[1] = msg(ST_NOTE_ON | {4'd0, chan}, note[6:0], it.data2_in,
                     it.length_in, it.time_in, 1'b1);
          n = 2;
        end else if (found) begin
          chan_note[chan] = FREE_MARK;
          r[0] = msg(ST_NOTE_OFF | {4'd0, chan}, note[6:0], it.data2_in,
                     it.length_in, it.time_in, 1'b1);
          n = 1;
        end
      end
    end else begin
      r[0] = msg(it.status_in, it.data1_in, it.data2_in, it.length_in, it.time_in, 1'b1);
      n = 1;
    end
    if (queue_it)
      for (int i = 0; i < n; i++) retuned_msgs.push_back(r[i]);
    return n;
  endfunction

  function automatic logic [6:0] pool_key();
    return ($urandom_range(99) < 90) ? 7'($urandom_range(23)) : 7'($urandom_range(127));
  endfunction

  function automatic in_t random_request(int on_pct);
    in_t it;
    int  roll;
    roll = $urandom_range(99);
    it.action     = ACT_EVENT;
    it.status_in  = 8'($urandom_range(255));
    it.data1_in   = 7'($urandom_range(127));
    it.data2_in   = 7'($urandom_range(127));
    it.length_in  = 2'($urandom_range(3, 1));
    it.time_in    = 13'($urandom_range(8191));
    it.entry_key  = 7'($urandom_range(127));
    it.entry_note = 8'($urandom_range(255));
    it.entry_bend = 14'($urandom_range(16383));
    if (roll < 10) begin
      it.action    = ACT_LOAD;
      it.entry_key = pool_key();
      roll = $urandom_range(99);
      if (roll >= 10)
        it.entry_note = (roll < 80) ? 8'($urandom_range(11)) : 8'($urandom_range(127));
    end else if (roll < 85) begin
      it.status_in = (($urandom_range(99) < on_pct) ? ST_NOTE_ON : ST_NOTE_OFF)
                     | 8'($urandom_range(15));
      it.data1_in  = pool_key();
    end else if (roll >= 95) begin
      it.action = 1'($urandom_range(1));
    end
    return it;
  endfunction

  task automatic send(input in_t it, input bit typed, input int count,
                      input out_t m0, input out_t m1, input int idle_pct,
                      output int nres);
    int gap;
    request <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    nres = retune_event(it, !typed);
    if (typed) begin
      if (count > 0) retuned_msgs.push_back(m0);
      if (count > 1) retuned_msgs.push_back(m1);
    end
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (retuned_msgs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && strobe) begin
      if (retuned_msgs.size() == 0) begin
        $error("unexpected result: status_out %0h", result.status_out);
        mismatches++;
      end else begin
        want = retuned_msgs.pop_front();
        check_field("status_out", want.status_out, result.status_out);
        check_field("data1_out", want.data1_out, result.data1_out);
        check_field("data2_out", want.data2_out, result.data2_out);
        check_field("length_out", want.length_out, result.length_out);
        check_field("time_out", want.time_out, result.time_out);
        check_field("last", want.last, result.last);
      end
    end
  end

  initial begin
    plan_row_t plan [21];
    int        idle_pct [3];
    int        targets [3];
    int        sent;
    int        on_pct;
    int        nres;
    in_t       it;

    idle_pct = '{6, 80, 0};
    targets  = '{130, 130, 140};
    plan = '{
      '{ev(ST_NOTE_ON, 60, 100, 3, 0), 1'b1, 0, NO_MSG, NO_MSG},
      '{ev(ST_NOTE_OFF, 60, 0, 3, 1), 1'b1, 0, NO_MSG, NO_MSG},
      '{ev(8'hb3, 7, 127, 3, 8191), 1'b1, 1, msg(8'hb3, 7, 127, 3, 8191, 1), NO_MSG},
      '{ev(8'h00, 0, 0, 1, 0), 1'b1, 1, msg(8'h00, 0, 0, 1, 0, 1), NO_MSG},
      '{ev(8'hff, 127, 127, 2, 4096), 1'b1, 1, msg(8'hff, 127, 127, 2, 4096, 1), NO_MSG},
      '{ev(8'he5, 85, 42, 3, 5461), 1'b1, 1, msg(8'he5, 85, 42, 3, 5461, 1), NO_MSG},
      '{ld(0, 0, 0), 1'b1, 0, NO_MSG, NO_MSG},
      '{ld(127, 127, 16383), 1'b1, 0, NO_MSG, NO_MSG},
      '{ld(64, 200, 5), 1'b1, 0, NO_MSG, NO_MSG},
      '{ld(65, 128, 9), 1'b1, 0, NO_MSG, NO_MSG},
      '{ld(1, 0, 8191), 1'b1, 0, NO_MSG, NO_MSG},
      '{ev(ST_NOTE_ON, 0, 0, 3, 100), 1'b1, 2,
        msg(ST_BEND, 0, 0, 3, 100, 0), msg(ST_NOTE_ON, 0, 0, 3, 100, 1)},
      '{ev(ST_NOTE_ON | 8'h0f, 127, 127, 3, 8191), 1'b1, 2,
        msg(ST_BEND | 8'd1, 127, 127, 3, 8191, 0),
        msg(ST_NOTE_ON | 8'd1, 127, 127, 3, 8191, 1)},
      '{ev(ST_NOTE_ON, 64, 50, 3, 7), 1'b1, 0, NO_MSG, NO_MSG},
      '{ev(ST_NOTE_ON, 65, 50, 3, 7), 1'b1, 0, NO_MSG, NO_MSG},
      '{ev(ST_NOTE_OFF | 8'h0f, 127, 64, 3, 200), 1'b1, 1,
        msg(ST_NOTE_OFF | 8'd1, 127, 64, 3, 200, 1), NO_MSG},
      '{ev(ST_NOTE_OFF, 127, 64, 3, 201), 1'b1, 0, NO_MSG, NO_MSG},
      '{ev(ST_NOTE_ON, 1, 33, 2, 300), 1'b0, 0, NO_MSG, NO_MSG},
      '{ev(ST_NOTE_OFF, 0, 10, 3, 301), 1'b0, 0, NO_MSG, NO_MSG},
      '{ev(ST_NOTE_ON, 0, 20, 3, 302), 1'b0, 0, NO_MSG, NO_MSG},
      '{ev(8'hc7, 5, 0, 2, 9), 1'b0, 0, NO_MSG, NO_MSG}
    };

    retune_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send(plan[i].req, plan[i].typed, plan[i].count, plan[i].msg0, plan[i].msg1,
           6, nres);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      sent = 0;
      on_pct = 50;
      while (sent < targets[ph]) begin
        if (sent % 40 == 0) on_pct = $urandom_range(80, 25);
        it = random_request(on_pct);
        send(it, 1'b0, 0, NO_MSG, NO_MSG, idle_pct[ph], nres);
        sent++;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
